### hdl/immediate_calculator_parser_defines.svh
// Assertion macros shared by the calculator RTL.
`ifndef IMMEDIATE_CALCULATOR_PARSER_DEFINES_SVH
`define IMMEDIATE_CALCULATOR_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ICP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("icp assertion failed");

// Next-cycle implication, checked out of reset.
`define ICP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("icp assertion failed");

`endif

### hdl/icp_pkg.sv
// Shared types, codes and helpers for the immediate calculator.
package icp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 5;

  localparam logic [7:0] CHAR_ADD  = 8'h2B;
  localparam logic [7:0] CHAR_SUB  = 8'h2D;
  localparam logic [7:0] CHAR_MUL  = 8'h78;
  localparam logic [7:0] CHAR_DIV  = 8'h2F;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [WORD_W-1:0] RADIX = 32'd10;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_EQ   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_PASS
  } alu_op_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_CALC,
    CS_EMIT
  } ctl_state_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_RUN,
    AS_FIX
  } alu_state_e;

  // mul computes a * b + c; div computes a / b (signed, truncating)
  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
    logic              div_zero;
  } alu_rsp_t;

  function automatic op_e decode_op(logic [7:0] ch);
    op_e op;
    case (ch)
      CHAR_ADD: op = OP_ADD;
      CHAR_SUB: op = OP_SUB;
      CHAR_MUL: op = OP_MUL;
      CHAR_DIV: op = OP_DIV;
      CHAR_EQ:  op = OP_EQ;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic alu_op_e alu_of(op_e op);
    alu_op_e a;
    case (op)
      OP_ADD:  a = ALU_ADD;
      OP_SUB:  a = ALU_SUB;
      OP_MUL:  a = ALU_MUL;
      OP_DIV:  a = ALU_DIV;
      default: a = ALU_PASS;
    endcase
    return a;
  endfunction

endpackage

### hdl/icp_alu.sv
// Iterative arithmetic unit: direct add/sub/pass, bit-serial multiply and divide.
module icp_alu (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  icp_pkg::alu_req_t req_i,
  output icp_pkg::alu_rsp_t rsp_o
);
  import icp_pkg::*;

  alu_state_e        state_q, state_d;
  alu_op_e           op_q, op_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] opa_q, opa_d;
  logic [WORD_W-1:0] opb_q, opb_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic              dz_q, dz_d;
  logic [WORD_W-1:0] res_q, res_d;
  logic [WORD_W:0]   trial;

  assign trial = {acc_q, opa_q[WORD_W-1]} - {1'b0, opb_q};

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    dz_d    = dz_q;
    res_d   = res_q;
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op;
          dz_d = 1'b0;
          case (req_i.op)
            ALU_ADD: begin
              res_d  = req_i.a + req_i.b;
              done_d = 1'b1;
            end
            ALU_SUB: begin
              res_d  = req_i.a - req_i.b;
              done_d = 1'b1;
            end
            ALU_MUL: begin
              acc_d   = req_i.c;
              opa_d   = req_i.a;
              opb_d   = req_i.b;
              state_d = AS_RUN;
            end
            ALU_DIV: begin
              if (req_i.b == '0) begin
                res_d  = '0;
                dz_d   = 1'b1;
                done_d = 1'b1;
              end else begin
                acc_d   = '0;
                opa_d   = req_i.a[WORD_W-1] ? (~req_i.a + 1'b1) : req_i.a;
                opb_d   = req_i.b[WORD_W-1] ? (~req_i.b + 1'b1) : req_i.b;
                neg_d   = req_i.a[WORD_W-1] ^ req_i.b[WORD_W-1];
                cnt_d   = '0;
                state_d = AS_RUN;
              end
            end
            default: begin
              res_d  = req_i.a;
              done_d = 1'b1;
            end
          endcase
        end
      end
      AS_RUN: begin
        if (op_q == ALU_MUL) begin
          if (opb_q == '0) begin
            res_d   = acc_q;
            done_d  = 1'b1;
            state_d = AS_IDLE;
          end else begin
            if (opb_q[0]) acc_d = acc_q + opa_q;
            opa_d = {opa_q[WORD_W-2:0], 1'b0};
            opb_d = {1'b0, opb_q[WORD_W-1:1]};
          end
        end else begin
          if (!trial[WORD_W]) begin
            acc_d = trial[WORD_W-1:0];
            opa_d = {opa_q[WORD_W-2:0], 1'b1};
          end else begin
            acc_d = {acc_q[WORD_W-2:0], opa_q[WORD_W-1]};
            opa_d = {opa_q[WORD_W-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(WORD_W - 1)) state_d = AS_FIX;
        end
      end
      AS_FIX: begin
        res_d   = neg_q ? (~opa_q + 1'b1) : opa_q;
        done_d  = 1'b1;
        state_d = AS_IDLE;
      end
      default: state_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
    res_q <= res_d;
  end

  assign rsp_o.busy     = (state_q != AS_IDLE);
  assign rsp_o.done     = done_q;
  assign rsp_o.result   = res_q;
  assign rsp_o.div_zero = dz_q;

endmodule

### hdl/immediate_calculator_parser.sv
// Immediate-execution calculator: takes one expression character per item and
// evaluates left to right with no precedence, emitting the value and a
// divide-by-zero flag after the item marked last. Every item passes through one
// shared iterative arithmetic unit, and the input is not ready until that item
// is finished. An operator applying add, subtract or equals, or the first
// operator, is computed directly; a digit runs a shift-add multiply by ten,
// stopping when the multiplier runs out; a pending multiply runs shift-add
// steps until the second operand runs out; a pending divide runs a 32-step
// restoring divider plus a sign fix, or is flagged directly on a zero divisor.
// A last item then passes through an emit state that hands the result to the
// output register once it is free, which then holds it until taken.
`include "immediate_calculator_parser_defines.svh"
module immediate_calculator_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] value_o,
  output logic        div_zero_o
);
  import icp_pkg::*;

  ctl_state_e        st_q, st_d;
  logic [7:0]        ch_q;
  logic              last_q;
  logic [WORD_W-1:0] first_q, first_d;
  logic [WORD_W-1:0] second_q, second_d;
  op_e               pend_q, pend_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] value_q;
  logic              dz_out_q;
  logic              load_out;
  logic              accept;
  op_e               in_op;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign in_ready_o = (st_q == CS_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_op      = decode_op(char_code_i);

  always_comb begin
    alu_req.start = accept;
    alu_req.c     = '0;
    if (in_op == OP_NONE) begin
      alu_req.op = ALU_MUL;
      alu_req.a  = (pend_q == OP_NONE) ? first_q : second_q;
      alu_req.b  = RADIX;
      alu_req.c  = {{(WORD_W-8){1'b0}}, char_code_i} - {{(WORD_W-8){1'b0}}, CHAR_ZERO};
    end else begin
      alu_req.op = alu_of(pend_q);
      alu_req.a  = first_q;
      alu_req.b  = second_q;
    end
  end

  icp_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    st_d        = st_q;
    first_d     = first_q;
    second_d    = second_q;
    pend_d      = pend_q;
    err_d       = err_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (st_q)
      CS_IDLE: begin
        if (accept) st_d = CS_CALC;
      end
      CS_CALC: begin
        if (alu_rsp.done) begin
          if (decode_op(ch_q) == OP_NONE) begin
            if (pend_q == OP_NONE) first_d = alu_rsp.result;
            else second_d = alu_rsp.result;
          end else begin
            first_d  = alu_rsp.result;
            second_d = '0;
            pend_d   = decode_op(ch_q);
            err_d    = err_q | alu_rsp.div_zero;
          end
          st_d = last_q ? CS_EMIT : CS_IDLE;
        end
      end
      CS_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          first_d     = '0;
          second_d    = '0;
          pend_d      = OP_NONE;
          err_d       = 1'b0;
          st_d        = CS_IDLE;
        end
      end
      default: st_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= CS_IDLE;
      first_q     <= '0;
      second_q    <= '0;
      pend_q      <= OP_NONE;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      first_q     <= first_d;
      second_q    <= second_d;
      pend_q      <= pend_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= char_code_i;
      last_q <= last_char_i;
    end
    if (load_out) begin
      value_q  <= first_q;
      dz_out_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign div_zero_o  = dz_out_q;

  `ICP_ASSERT_NXT(a_one_item, clk_i, rst_ni, accept, !in_ready_o)
  `ICP_ASSERT_IMP(a_alu_free, clk_i, rst_ni, alu_req.start, !alu_rsp.busy)
  `ICP_ASSERT_IMP(a_done_in_calc, clk_i, rst_ni, alu_rsp.done, st_q == CS_CALC)
  `ICP_ASSERT_NXT(a_clear_after_emit, clk_i, rst_ni, load_out,
                  out_valid_q && first_q == '0 && second_q == '0 && pend_q == OP_NONE && !err_q)

endmodule

### verif/immediate_calculator_parser_tb.sv
// Self-checking testbench for the immediate calculator with random stimulus.
`timescale 1ns / 100ps

module immediate_calculator_parser_tb;
  import icp_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT  = 1500;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int SCRIPT_LEN   = 28;

  typedef struct packed {
    logic [31:0] value;
    logic        dz;
  } calc_total_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        lst;
    logic        typed;
    logic [31:0] value;
    logic        dz;
  } script_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic        div_zero_o;

  logic [31:0] run_lhs     = '0;
  logic [31:0] run_rhs     = '0;
  op_e         run_op      = OP_NONE;
  logic        run_div_err = 1'b0;

  calc_total_t totals_due[$];
  int          mismatch_count = 0;
  int          items_taken    = 0;
  int          idle_cycles    = 0;
  bit          held_off       = 0;
  wire         calm = (items_taken >= 700) && (items_taken < 1000);

  logic [7:0] op_chars [5] = '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV, CHAR_EQ};

  // special cases: extreme bytes, divide by zero, all operators with
  // truncation, equals applied, pending op at end, minimum over minus one
  script_row_t script [SCRIPT_LEN] = '{
    '{8'h00,    1'b1, 1'b1, 32'hFFFF_FFD0, 1'b0},
    '{8'hFF,    1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_DIV, 1'b0, 1'b0, 32'h0,         1'b0},
    '{"0",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_EQ,  1'b1, 1'b1, 32'h0,         1'b1},
    '{"6",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_SUB, 1'b0, 1'b0, 32'h0,         1'b0},
    '{"9",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_MUL, 1'b0, 1'b0, 32'h0,         1'b0},
    '{"4",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_DIV, 1'b0, 1'b0, 32'h0,         1'b0},
    '{"5",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_EQ,  1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_ADD, 1'b1, 1'b1, 32'hFFFF_FFFE, 1'b0},
    '{"2",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"1",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"4",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"7",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"4",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"8",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"3",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"6",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"4",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"8",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_DIV, 1'b0, 1'b0, 32'h0,         1'b0},
    '{"1",      1'b0, 1'b0, 32'h0,         1'b0},
    '{"%",      1'b0, 1'b0, 32'h0,         1'b0},
    '{CHAR_EQ,  1'b1, 1'b1, 32'h8000_0000, 1'b0}
  };

  immediate_calculator_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .div_zero_o  (div_zero_o)
  );

  always #6 clk_i = ~clk_i;

  // left-to-right evaluation of one character; returns 1 when a total is due
  function automatic bit calc_step(input logic [7:0] ch, input logic lst,
                                   output calc_total_t total);
    op_e         op;
    logic [31:0] digit;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    total = '0;
    case (ch)
      CHAR_ADD: op = OP_ADD;
      CHAR_SUB: op = OP_SUB;
      CHAR_MUL: op = OP_MUL;
      CHAR_DIV: op = OP_DIV;
      CHAR_EQ:  op = OP_EQ;
      default:  op = OP_NONE;
    endcase
    if (op == OP_NONE) begin
      digit = {24'd0, ch} - {24'd0, CHAR_ZERO};
      if (run_op == OP_NONE) run_lhs = run_lhs * RADIX + digit;
      else run_rhs = run_rhs * RADIX + digit;
    end else begin
      if (run_op != OP_NONE) begin
        case (run_op)
          OP_ADD: run_lhs = run_lhs + run_rhs;
          OP_SUB: run_lhs = run_lhs - run_rhs;
          OP_MUL: run_lhs = run_lhs * run_rhs;
          OP_DIV: begin
            if (run_rhs == '0) begin
              run_div_err = 1'b1;
              run_lhs = '0;
            end else begin
              mag_a = run_lhs[31] ? -run_lhs : run_lhs;
              mag_b = run_rhs[31] ? -run_rhs : run_rhs;
              quot = mag_a / mag_b;
              run_lhs = (run_lhs[31] ^ run_rhs[31]) ? -quot : quot;
            end
          end
          default: run_lhs = run_lhs;
        endcase
        run_rhs = '0;
      end
      run_op = op;
    end
    if (!lst) return 1'b0;
    total.value = run_lhs;
    total.dz = run_div_err;
    run_lhs = '0;
    run_rhs = '0;
    run_op = OP_NONE;
    run_div_err = 1'b0;
    return 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [7:0] ch, input logic lst, input logic typed,
                       input logic [31:0] t_value, input logic t_dz);
    calc_total_t total;
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= ch;
    last_char_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    if (calc_step(ch, lst, total)) begin
      if (typed) begin
        total.value = t_value;
        total.dz = t_dz;
      end
      totals_due.push_back(total);
    end
    items_taken++;
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] expr[$];
    int         terms;
    int         ndig;
    int         ending;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < SCRIPT_LEN; i++)
      offer(script[i].ch, script[i].lst, script[i].typed, script[i].value, script[i].dz);
    while (items_taken < RANDOM_ITEMS) begin
      expr.delete();
      if ($urandom_range(9) == 0) begin
        ndig = $urandom_range(8, 1);
        for (int k = 0; k < ndig; k++) expr.push_back(8'($urandom_range(255)));
      end else begin
        terms = $urandom_range(5, 1);
        for (int t = 0; t < terms; t++) begin
          if (t != 0) expr.push_back(op_chars[$urandom_range(4)]);
          if ($urandom_range(9) == 0) begin
            expr.push_back(CHAR_ZERO);
          end else if ($urandom_range(19) != 0) begin
            ndig = ($urandom_range(15) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
            for (int k = 0; k < ndig; k++)
              expr.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                       : 8'(CHAR_ZERO + $urandom_range(9)));
          end
        end
        ending = $urandom_range(2);
        if (ending == 1) expr.push_back(CHAR_EQ);
        else if (ending == 2 || expr.size() == 0) expr.push_back(op_chars[$urandom_range(4)]);
      end
      for (int k = 0; k < expr.size(); k++)
        offer(expr[k], (k == expr.size() - 1) || ($urandom_range(31) == 0), 1'b0, '0, 1'b0);
    end
    in_valid_i <= 1'b0;
    wait (totals_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && totals_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && items_taken >= 300) begin
        held_off = 1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk_i) begin
    calc_total_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (totals_due.size() == 0) begin
        $display("%0t: unexpected total value=%0d div_zero=%0b",
                 $time, value_o, div_zero_o);
        mismatch_count++;
      end else begin
        due = totals_due.pop_front();
        if (value_o !== due.value) begin
          $display("%0t: value mismatch, expected %0d got %0d",
                   $time, $signed(due.value), value_o);
          mismatch_count++;
        end
        if (div_zero_o !== due.dz) begin
          $display("%0t: div_zero mismatch, expected %0b got %0b",
                   $time, due.dz, div_zero_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
